/* src/qte_pkg.sv */
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

    localparam int PROD_W     = 32;
    localparam int SUM_W      = 35;
    localparam int CORDIC_W   = 36;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_W     = 62;
    localparam int THR_W      = 15;
    localparam logic [THR_W-1:0] THR_RESET = 15'd32765;

    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                z;
        logic                       zero;
    } t_cordic;

    typedef struct packed {
        logic [SQRT_W-1:0] v;
        logic [SQRT_W-1:0] res;
    } t_sqrt;

endpackage

/* src/qte_sqrt_cell.sv */
// One registered step of the bit-by-bit integer square root.
module qte_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  qte_pkg::t_sqrt i_d,
    output qte_pkg::t_sqrt o_d
);
    import qte_pkg::*;

    localparam int BP = 60 - 2 * IDX;

    logic [SQRT_W-1:0] w_bit;
    logic [SQRT_W-1:0] w_trial;
    t_sqrt             n_d;
    t_sqrt             r_d;

    assign w_bit   = SQRT_W'(1) << BP;
    assign w_trial = i_d.res + w_bit;

    always_comb begin
        if (i_d.v >= w_trial) begin
            n_d.v   = i_d.v - w_trial;
            n_d.res = (i_d.res >> 1) + w_bit;
        end else begin
            n_d.v   = i_d.v;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

/* src/qte_cordic_cell.sv */
// One registered CORDIC vectoring micro-rotation.
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  qte_pkg::t_cordic i_d,
    output qte_pkg::t_cordic o_d
);
    import qte_pkg::*;

    t_cordic n_d;
    t_cordic r_d;

    always_comb begin
        n_d.zero = i_d.zero;
        if (!i_d.y[CORDIC_W-1]) begin
            n_d.x = i_d.x + (i_d.y >>> IDX);
            n_d.y = i_d.y - (i_d.x >>> IDX);
            n_d.z = i_d.z + ATAN_TAB[IDX];
        end else begin
            n_d.x = i_d.x - (i_d.y >>> IDX);
            n_d.y = i_d.y + (i_d.x >>> IDX);
            n_d.z = i_d.z - ATAN_TAB[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

/* src/qte_cordic.sv */
// Pipelined CORDIC atan2 unit: pre-rotation, a row of cells and rounding.
module qte_cordic #(
    parameter int STAGES = 16,
    parameter int AW     = 16
) (
    input  logic                            i_clk,
    input  logic signed [qte_pkg::SUM_W-1:0] i_y,
    input  logic signed [qte_pkg::SUM_W-1:0] i_x,
    output logic [AW-1:0]                   o_angle
);
    import qte_pkg::*;

    localparam logic [31:0] RND_ADD = (AW < 32) ? (32'd1 << ((AW < 32) ? (31 - AW) : 0))
                                                : 32'd0;

    t_cordic     n_pre;
    t_cordic     r_pre;
    t_cordic     w_c [0:STAGES];
    logic [31:0] w_z;
    logic [31:0] w_sum;
    logic [AW-1:0] r_angle;

    always_comb begin
        n_pre.zero = (i_x == '0) && (i_y == '0);
        if (i_x[SUM_W-1]) begin
            n_pre.x = -CORDIC_W'(i_x);
            n_pre.y = -CORDIC_W'(i_y);
            n_pre.z = 32'h8000_0000;
        end else begin
            n_pre.x = CORDIC_W'(i_x);
            n_pre.y = CORDIC_W'(i_y);
            n_pre.z = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
    end

    assign w_c[0] = r_pre;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        qte_cordic_cell #(.IDX(g)) u_cell (
            .i_clk (i_clk),
            .i_d   (w_c[g]),
            .o_d   (w_c[g+1])
        );
    end

    assign w_z   = w_c[STAGES].zero ? 32'd0 : w_c[STAGES].z;
    assign w_sum = w_z + RND_ADD;

    always_ff @(posedge i_clk) begin
        r_angle <= w_sum[31 -: AW];
    end

    assign o_angle = r_angle;
endmodule

/* src/quaternion_to_euler_angles_unit.sv */
// Top level of the quaternion to heading, pitch and bank converter.
// The converter is a free-running pipeline: one quaternion can be started in every clock
// cycle and o_busy stays low. Each transaction yields exactly one result, shown for one cycle
// with o_valid; the pipeline depth comes from the product and sum stages, the 31-step square
// root for the pitch cosine and the CORDIC cell rows.
// The receiver cannot stall the pipeline and must take every result when it appears.
module quaternion_to_euler_angles_unit #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int ANGLE_WIDTH     = 16,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_cfg_we,
    input  logic [qte_pkg::THR_W-1:0]           i_cfg_wdata,
    input  logic                                i_mode,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_quat_z,
    output logic                                o_valid,
    output logic signed [ANGLE_WIDTH-1:0]       o_heading,
    output logic signed [ANGLE_WIDTH-1:0]       o_pitch,
    output logic signed [ANGLE_WIDTH-1:0]       o_bank,
    output logic                                o_gimbal_locked
);
    import qte_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int VL  = CORDIC_STAGES + 38;
    localparam int DA  = 32;
    localparam int DL  = CORDIC_STAGES + 34;
    localparam int PSR = (2 * CW > 32) ? (2 * CW - 32) : 0;
    localparam int PSL = (2 * CW < 32) ? (32 - 2 * CW) : 0;
    localparam int PSH = (AW < 32) ? (32 - AW) : 0;
    localparam logic signed [SUM_W-1:0] RNDP =
        (AW < 32) ? (SUM_W'(1) << ((AW < 32) ? (31 - AW) : 0)) : '0;
    localparam logic signed [SUM_W-1:0] ONE  = SUM_W'(1) << 30;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << 29;

    function automatic logic signed [PROD_W-1:0] mul_q30(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [2*CW-1:0] p;
        logic signed [63:0]     e;
        p = a * b;
        e = 64'(p);
        e = (e >>> PSR) <<< PSL;
        return e[PROD_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] v);
        return SUM_W'(v);
    endfunction

    logic [THR_W-1:0]          r_thr;
    logic [VL-1:0]             r_vld;

    logic                      r_s0_mode;
    logic signed [CW-1:0]      r_s0_w, r_s0_x, r_s0_y, r_s0_z;

    logic                      r_s1_mode;
    logic signed [PROD_W-1:0]  r_wx, r_wy, r_wz, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;

    logic signed [SUM_W-1:0]   n_sp, n_asp, n_hy, n_hx, n_by, n_bx, n_clamp, n_lp_full;
    logic                      n_lock;
    logic signed [SUM_W-1:0]   r_sp, r_hy, r_hx, r_by, r_bx;
    logic                      r_lock;
    logic [AW-1:0]             r_lpitch;
    logic [29:0]               r_asp30;

    logic [59:0]               r_sq;
    t_sqrt                     w_sq [0:SQRT_STEPS];
    logic signed [SUM_W-1:0]   w_cp;

    logic signed [SUM_W-1:0]   r_dl_sp [0:DA-1];
    logic signed [SUM_W-1:0]   r_dl_hy [0:DA-1];
    logic signed [SUM_W-1:0]   r_dl_hx [0:DA-1];
    logic signed [SUM_W-1:0]   r_dl_by [0:DA-1];
    logic signed [SUM_W-1:0]   r_dl_bx [0:DA-1];
    logic                      r_dl_lk [0:DL-1];
    logic [AW-1:0]             r_dl_lp [0:DL-1];

    logic [AW-1:0]             w_head, w_pitch, w_bank;
    logic [AW-1:0]             r_heading, r_pitch, r_bank;
    logic                      r_locked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_vld <= {r_vld[VL-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_mode <= i_mode;
        r_s0_w    <= i_quat_w;
        r_s0_x    <= i_quat_x;
        r_s0_y    <= i_quat_y;
        r_s0_z    <= i_quat_z;

        r_s1_mode <= r_s0_mode;
        r_wx      <= mul_q30(r_s0_w, r_s0_x);
        r_wy      <= mul_q30(r_s0_w, r_s0_y);
        r_wz      <= mul_q30(r_s0_w, r_s0_z);
        r_xx      <= mul_q30(r_s0_x, r_s0_x);
        r_yy      <= mul_q30(r_s0_y, r_s0_y);
        r_zz      <= mul_q30(r_s0_z, r_s0_z);
        r_xy      <= mul_q30(r_s0_x, r_s0_y);
        r_xz      <= mul_q30(r_s0_x, r_s0_z);
        r_yz      <= mul_q30(r_s0_y, r_s0_z);
    end

    always_comb begin
        if (r_s1_mode) begin
            n_sp = -((ext(r_yz) + ext(r_wx)) <<< 1);
        end else begin
            n_sp = -((ext(r_yz) - ext(r_wx)) <<< 1);
        end
        n_asp  = n_sp[SUM_W-1] ? -n_sp : n_sp;
        n_lock = n_asp > $signed({{(SUM_W-THR_W-15){1'b0}}, r_thr, 15'd0});

        if (n_sp > ONE) begin
            n_clamp = ONE;
        end else if (n_sp < -ONE) begin
            n_clamp = -ONE;
        end else begin
            n_clamp = n_sp;
        end
        n_lp_full = (n_clamp + RNDP) >>> PSH;

        if (n_lock) begin
            n_hy = r_s1_mode ? (-ext(r_xz) - ext(r_wy)) : (-ext(r_xz) + ext(r_wy));
            n_hx = HALF - ext(r_yy) - ext(r_zz);
        end else begin
            n_hy = r_s1_mode ? (ext(r_xz) - ext(r_wy)) : (ext(r_xz) + ext(r_wy));
            n_hx = HALF - ext(r_xx) - ext(r_yy);
        end
        n_by = r_s1_mode ? (ext(r_xy) - ext(r_wz)) : (ext(r_xy) + ext(r_wz));
        n_bx = HALF - ext(r_xx) - ext(r_zz);
    end

    always_ff @(posedge i_clk) begin
        r_sp     <= n_sp;
        r_hy     <= n_hy;
        r_hx     <= n_hx;
        r_by     <= n_by;
        r_bx     <= n_bx;
        r_lock   <= n_lock;
        r_lpitch <= n_lp_full[AW-1:0];
        r_asp30  <= n_lock ? 30'd0 : n_asp[29:0];

        r_sq     <= r_asp30 * r_asp30;
    end

    assign w_sq[0].v   = (SQRT_W'(1) << 60) - SQRT_W'(r_sq);
    assign w_sq[0].res = '0;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        qte_sqrt_cell #(.IDX(g)) u_sqrt (
            .i_clk (i_clk),
            .i_d   (w_sq[g]),
            .o_d   (w_sq[g+1])
        );
    end

    assign w_cp = $signed({1'b0, w_sq[SQRT_STEPS].res[SUM_W-2:0]});

    always_ff @(posedge i_clk) begin
        r_dl_sp[0] <= r_sp;
        r_dl_hy[0] <= r_hy;
        r_dl_hx[0] <= r_hx;
        r_dl_by[0] <= r_by;
        r_dl_bx[0] <= r_bx;
        for (int k = 1; k < DA; k++) begin
            r_dl_sp[k] <= r_dl_sp[k-1];
            r_dl_hy[k] <= r_dl_hy[k-1];
            r_dl_hx[k] <= r_dl_hx[k-1];
            r_dl_by[k] <= r_dl_by[k-1];
            r_dl_bx[k] <= r_dl_bx[k-1];
        end
        r_dl_lk[0] <= r_lock;
        r_dl_lp[0] <= r_lpitch;
        for (int k = 1; k < DL; k++) begin
            r_dl_lk[k] <= r_dl_lk[k-1];
            r_dl_lp[k] <= r_dl_lp[k-1];
        end
    end

    qte_cordic #(.STAGES(CORDIC_STAGES), .AW(AW)) u_cordic_head (
        .i_clk   (i_clk),
        .i_y     (r_dl_hy[DA-1]),
        .i_x     (r_dl_hx[DA-1]),
        .o_angle (w_head)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES), .AW(AW)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_y     (r_dl_sp[DA-1]),
        .i_x     (w_cp),
        .o_angle (w_pitch)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES), .AW(AW)) u_cordic_bank (
        .i_clk   (i_clk),
        .i_y     (r_dl_by[DA-1]),
        .i_x     (r_dl_bx[DA-1]),
        .o_angle (w_bank)
    );

    always_ff @(posedge i_clk) begin
        r_heading <= w_head;
        r_pitch   <= r_dl_lk[DL-1] ? r_dl_lp[DL-1] : w_pitch;
        r_bank    <= r_dl_lk[DL-1] ? '0 : w_bank;
        r_locked  <= r_dl_lk[DL-1];
    end

    assign o_busy          = 1'b0;
    assign o_valid         = r_vld[VL-1];
    assign o_heading       = r_heading;
    assign o_pitch         = r_pitch;
    assign o_bank          = r_bank;
    assign o_gimbal_locked = r_locked;

    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, VL))
        else $error("result without a matching transaction");

    a_locked_bank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gimbal_locked) |-> (o_bank == '0))
        else $error("bank not zero under gimbal lock");

    a_locked_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gimbal_locked) |->
            ((o_pitch <= $signed(AW'(1) << (AW - 2)))
             && (o_pitch >= -$signed(AW'(1) << (AW - 2)))))
        else $error("locked pitch beyond a quarter turn");
endmodule

/* tb/tb_quaternion_to_euler_angles_unit.sv */
// Testbench for the quaternion to heading, pitch and bank converter with a built-in predictor.
module tb_quaternion_to_euler_angles_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int AW = 16;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 38;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED = 16;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [AW-1:0] heading;
        logic [AW-1:0] pitch;
        logic [AW-1:0] bank;
        logic          locked;
    } t_angles;

    typedef struct {
        logic                 mode;
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 known;
        t_angles              want;
    } t_quat_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic                 i_cfg_we = 1'b0;
    logic [14:0]          i_cfg_wdata = '0;
    logic                 i_mode = 1'b0;
    logic signed [CW-1:0] i_quat_w = '0;
    logic signed [CW-1:0] i_quat_x = '0;
    logic signed [CW-1:0] i_quat_y = '0;
    logic signed [CW-1:0] i_quat_z = '0;
    logic                 o_valid;
    logic signed [AW-1:0] o_heading;
    logic signed [AW-1:0] o_pitch;
    logic signed [AW-1:0] o_bank;
    logic                 o_gimbal_locked;

    t_angles     expected_angles[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    logic [14:0] lock_thr = qte_pkg::THR_RESET;
    t_quat_row   directed[N_DIRECTED];

    quaternion_to_euler_angles_unit #(
        .COMPONENT_WIDTH(CW), .ANGLE_WIDTH(AW), .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .i_mode(i_mode),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .o_valid(o_valid), .o_heading(o_heading),
        .o_pitch(o_pitch), .o_bank(o_bank), .o_gimbal_locked(o_gimbal_locked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitpos;
        res = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= res + bitpos) begin
                v = v - (res + bitpos);
                res = (res >> 1) + bitpos;
            end else begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        longint nx;
        longint ny;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                acc = acc + qte_pkg::ATAN_TAB[i];
            end else begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                acc = acc - qte_pkg::ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return acc;
    endfunction

    function automatic logic [AW-1:0] round_angle(logic [31:0] a);
        logic [31:0] r;
        r = (a + (32'd1 << (31 - AW))) >> (32 - AW);
        return r[AW-1:0];
    endfunction

    function automatic t_angles predict_angles(logic inv, longint w, longint x, longint y,
                                               longint z, logic [14:0] thr_reg);
        t_angles r;
        longint wx, wy, wz, xx, yy, zz, xy, xz, yz, sp, asp, c, half, cp;
        wx = w * x; wy = w * y; wz = w * z;
        xx = x * x; yy = y * y; zz = z * z;
        xy = x * y; xz = x * z; yz = y * z;
        half = longint'(ONE_Q30) / 2;
        sp = inv ? -2 * (yz + wx) : -2 * (yz - wx);
        asp = sp < 0 ? -sp : sp;
        if (asp > (longint'(thr_reg) << 15)) begin
            c = sp;
            if (c > longint'(ONE_Q30)) c = ONE_Q30;
            if (c < -longint'(ONE_Q30)) c = -longint'(ONE_Q30);
            c = floor_shift(c + (64'sd1 <<< (31 - AW)), 32 - AW);
            r.pitch = c[AW-1:0];
            r.heading = round_angle(vector_angle(inv ? -xz - wy : -xz + wy,
                                                 half - yy - zz));
            r.bank = '0;
            r.locked = 1'b1;
        end else begin
            cp = longint'(int_sqrt((64'd1 << 60) - 64'(asp) * 64'(asp)));
            r.pitch = round_angle(vector_angle(sp, cp));
            r.heading = round_angle(vector_angle(inv ? xz - wy : xz + wy, half - xx - yy));
            r.bank = round_angle(vector_angle(inv ? xy - wz : xy + wz, half - xx - zz));
            r.locked = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("Mismatch: %s", msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && o_valid) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected result transaction");
            end else begin
                want = expected_angles.pop_front();
                if (o_heading !== want.heading)
                    report_mismatch($sformatf("heading got %0d, expected %0d",
                                              o_heading, $signed(want.heading)));
                if (o_pitch !== want.pitch)
                    report_mismatch($sformatf("pitch got %0d, expected %0d",
                                              o_pitch, $signed(want.pitch)));
                if (o_bank !== want.bank)
                    report_mismatch($sformatf("bank got %0d, expected %0d",
                                              o_bank, $signed(want.bank)));
                if (o_gimbal_locked !== want.locked)
                    report_mismatch($sformatf("gimbal_locked got %0d, expected %0d",
                                              o_gimbal_locked, want.locked));
            end
        end
        if (i_rst_n && !((i_start && !o_busy) || o_valid)) idle_cycles++;
        else idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_quat(logic m, logic signed [CW-1:0] w, logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                             logic known, t_angles want, bit allow_gaps);
        t_angles pred;
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_mode <= m;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pred = predict_angles(m, w, x, y, z, lock_thr);
        if (known && pred !== want) begin
            report_mismatch("predictor disagrees with table row");
        end
        expected_angles.push_back(pred);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [14:0] thr);
        i_start <= 1'b0;
        while (expected_angles.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= thr;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lock_thr = thr;
    endtask

    task automatic send_random(int n, bit allow_gaps);
        logic signed [CW-1:0] q[4];
        t_angles none;
        int kind;
        none = '0;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            for (int j = 0; j < 4; j++) q[j] = CW'($urandom);
            if (kind < 6) begin
                // Shrunken quaternions: halve each component so the norm stays at most one.
                for (int j = 0; j < 4; j++) q[j] = q[j] >>> 1;
            end else if (kind < 8) begin
                // Near gimbal lock: x equal to w up to sign, with y and z small.
                q[1] = ($urandom_range(0, 1) ? q[0] : -q[0]) >>> 1;
                q[0] = q[0] >>> 1;
                q[2] = CW'($urandom_range(0, 300)) - 16'sd150;
                q[3] = CW'($urandom_range(0, 300)) - 16'sd150;
            end
            send_quat($urandom_range(0, 1), q[0], q[1], q[2], q[3], 1'b0, none, allow_gaps);
        end
    endtask

    initial begin
        t_angles z0;
        z0 = '0;
        directed[0]  = '{1'b0, 16'sh7FFF, 0, 0, 0, 1'b1, z0};
        directed[1]  = '{1'b1, 16'sh7FFF, 0, 0, 0, 1'b1, z0};
        directed[2]  = '{1'b0, 0, 0, 0, 0, 1'b1, z0};
        directed[3]  = '{1'b0, 16'sh5A82, 16'sh5A82, 0, 0, 1'b0, z0};
        directed[4]  = '{1'b1, 16'sh5A82, 16'sh5A82, 0, 0, 1'b0, z0};
        directed[5]  = '{1'b0, 16'sh5A82, 0, 16'sh5A82, 0, 1'b0, z0};
        directed[6]  = '{1'b0, 16'sh5A82, 0, 0, 16'sh5A82, 1'b0, z0};
        directed[7]  = '{1'b0, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000, 1'b0, z0};
        directed[8]  = '{1'b1, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000, 1'b0, z0};
        directed[9]  = '{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, z0};
        directed[10] = '{1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, z0};
        directed[11] = '{1'b0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, z0};
        directed[12] = '{1'b0, 16'sh4000, 16'shC000, 16'sh4000, 16'shC000, 1'b0, z0};
        directed[13] = '{1'b0, 0, 0, 16'sh8000, 0, 1'b0, z0};
        directed[14] = '{1'b1, 16'sh8000, 0, 0, 16'sh8000, 1'b0, z0};
        directed[15] = '{1'b0, 16'sh5A82, 16'shA57E, 16'sh0001, 16'shFFFF, 1'b0, z0};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k])
            send_quat(directed[k].mode, directed[k].w, directed[k].x, directed[k].y,
                      directed[k].z, directed[k].known, directed[k].want, 1'b0);
        write_threshold(15'd0);
        foreach (directed[k])
            send_quat(directed[k].mode, directed[k].w, directed[k].x, directed[k].y,
                      directed[k].z, 1'b0, z0, 1'b0);
        send_random(300, 1'b1);
        write_threshold(15'h7FFF);
        send_random(300, 1'b1);
        write_threshold(15'd24000);
        send_random(400, 1'b1);
        write_threshold(15'($urandom_range(0, 32767)));
        send_random(300, 1'b1);
        write_threshold(qte_pkg::THR_RESET);
        send_random(350, 1'b1);
        send_random(300, 1'b0);
        i_start <= 1'b0;
        while (expected_angles.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* files.f */
src/qte_pkg.sv
src/qte_sqrt_cell.sv
src/qte_cordic_cell.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles_unit.sv
tb/tb_quaternion_to_euler_angles_unit.sv
